### rtl/core/stq_pkg.sv
package stq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned NUM_IDS       = 64;
  localparam int unsigned ID_W          = 6;
  localparam int unsigned TIME_W        = 32;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_ADJUST = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_TICK   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_STATUS   = 2'd0,
    KIND_EXPIRED  = 2'd1,
    KIND_NONE_DUE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_FULL       = 2'd1,
    STS_ACTIVE     = 2'd2,
    STS_NOT_ACTIVE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_SHL  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   owner;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    cell_op_e          op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] expiry;
  } cmd_t;

endpackage

### rtl/core/stq_cell.sv
module stq_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stq_pkg::cmd_t  cmd_i,
  input  logic           shl_i,
  input  stq_pkg::entry_t prev_i,
  input  logic           prev_le_i,
  input  stq_pkg::entry_t next_i,
  output stq_pkg::entry_t ent_o,
  output logic           le_o,
  output logic           hit_o
);

  logic                       valid_q, valid_d;
  logic [stq_pkg::ID_W-1:0]   owner_q, owner_d;
  logic [stq_pkg::TIME_W-1:0] expiry_q, expiry_d;

  assign ent_o = '{valid: valid_q, owner: owner_q, expiry: expiry_q};
  assign le_o  = valid_q && (expiry_q <= cmd_i.expiry);
  assign hit_o = valid_q && (owner_q == cmd_i.id);

  always_comb begin
    valid_d  = valid_q;
    owner_d  = owner_q;
    expiry_d = expiry_q;
    unique case (cmd_i.op)
      stq_pkg::CELL_INS: begin
        // keep entries not later than the new one, open a slot behind them
        if (!le_o) begin
          if (prev_le_i) begin
            valid_d  = 1'b1;
            owner_d  = cmd_i.id;
            expiry_d = cmd_i.expiry;
          end else begin
            valid_d  = prev_i.valid;
            owner_d  = prev_i.owner;
            expiry_d = prev_i.expiry;
          end
        end
      end
      stq_pkg::CELL_SHL: begin
        if (shl_i) begin
          valid_d  = next_i.valid;
          owner_d  = next_i.owner;
          expiry_d = next_i.expiry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    owner_q  <= owner_d;
    expiry_q <= expiry_d;
  end

endmodule

### rtl/core/sorted_expiry_timer_queue.sv
// Sorted expiry timer queue.
// Input channel (in_valid_i / in_ready_o) takes one request: add, adjust,
// delete or tick. Output channel (out_valid_o / out_ready_i) returns results;
// last_o marks the final result of a request.
// Timers sit in a row of DEPTH cells kept in ascending expiry order; each
// cell compares its own expiry in parallel, so an insert or a removal
// shifts the whole row at once.
// Add and delete: status result registered at acceptance.
// Adjust: remove, then re-insert; status result registered at acceptance.
// Tick: nothing due gives one result at acceptance; otherwise one expired
// timer is popped from the head per cycle unless stalled; then the block idles.
// A new request is taken when the block is idle and the output register is
// empty or being drained in the same cycle.
// A stalled receiver holds the output register and pauses expiry popping.
// Reset empties the row and clears all active flags; the block is ready
// as soon as reset is released.
module sorted_expiry_timer_queue #(
  parameter int unsigned DEPTH = stq_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 req_type_i,
  input  logic [stq_pkg::ID_W-1:0]   timer_id_i,
  input  logic [stq_pkg::TIME_W-1:0] expire_time_i,
  input  logic [stq_pkg::TIME_W-1:0] now_time_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [stq_pkg::ID_W-1:0]   expired_id_o,
  output logic [stq_pkg::TIME_W-1:0] expired_at_o,
  output logic [1:0]                 status_o,
  output logic                       last_o
);

  localparam int unsigned LVLS = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADJ,
    ST_TICK
  } state_e;

  state_e                     state_q, state_d;
  logic [stq_pkg::NUM_IDS-1:0] active_q, active_d;
  logic [stq_pkg::ID_W-1:0]   id_q, id_d;
  logic [stq_pkg::TIME_W-1:0] exp_q, exp_d;
  logic [stq_pkg::TIME_W-1:0] now_q, now_d;

  logic                       out_valid_q, out_valid_d;
  logic [1:0]                 kind_q, kind_d;
  logic [stq_pkg::ID_W-1:0]   oid_q, oid_d;
  logic [stq_pkg::TIME_W-1:0] oat_q, oat_d;
  logic [1:0]                 status_q, status_d;
  logic                       last_q, last_d;

  stq_pkg::cmd_t              cmd;
  stq_pkg::entry_t            ent [DEPTH];
  logic [DEPTH-1:0]           le;
  logic [DEPTH-1:0]           hit;
  logic [DEPTH-1:0]           pfx;
  logic [DEPTH-1:0]           shl;
  logic [DEPTH-1:0]           vld;

  logic slot_free, accept, full, id_act, head_due, next_due;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    stq_pkg::entry_t prev_ent;
    stq_pkg::entry_t next_ent;
    logic            prev_le;
    if (i == 0) begin : g_first
      assign prev_ent = '0;
      assign prev_le  = 1'b1;
    end else begin : g_mid
      assign prev_ent = ent[i-1];
      assign prev_le  = le[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign next_ent = '0;
    end else begin : g_nxt
      assign next_ent = ent[i+1];
    end

    stq_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .shl_i    (shl[i]),
      .prev_i   (prev_ent),
      .prev_le_i(prev_le),
      .next_i   (next_ent),
      .ent_o    (ent[i]),
      .le_o     (le[i]),
      .hit_o    (hit[i])
    );

    assign vld[i] = ent[i].valid;
  end

  // every cell at or after the matching one pulls from its right neighbor
  always_comb begin
    pfx = hit;
    for (int l = 0; l < LVLS; l++) begin
      pfx = pfx | (pfx << (1 << l));
    end
  end

  assign full      = vld[DEPTH-1];
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign accept    = in_valid_i && in_ready_o;
  assign id_act    = active_q[timer_id_i];
  assign head_due  = ent[0].valid && (ent[0].expiry <= now_time_i);
  assign next_due  = ent[1].valid && (ent[1].expiry <= now_q);

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    id_d        = id_q;
    exp_d       = exp_q;
    now_d       = now_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    oid_d       = oid_q;
    oat_d       = oat_q;
    status_d    = status_q;
    last_d      = last_q;
    cmd         = '{op: stq_pkg::CELL_HOLD, id: timer_id_i, expiry: expire_time_i};
    shl         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          kind_d      = stq_pkg::KIND_STATUS;
          oid_d       = timer_id_i;
          oat_d       = '0;
          status_d    = stq_pkg::STS_OK;
          last_d      = 1'b1;
          unique case (req_type_i)
            stq_pkg::REQ_ADD: begin
              if (id_act) begin
                status_d = stq_pkg::STS_ACTIVE;
              end else if (full) begin
                status_d = stq_pkg::STS_FULL;
              end else begin
                cmd.op               = stq_pkg::CELL_INS;
                active_d[timer_id_i] = 1'b1;
              end
            end
            stq_pkg::REQ_ADJUST: begin
              if (!id_act) begin
                status_d = stq_pkg::STS_NOT_ACTIVE;
              end else begin
                // drop the old entry now, re-insert next cycle
                cmd.op  = stq_pkg::CELL_SHL;
                shl     = pfx;
                id_d    = timer_id_i;
                exp_d   = expire_time_i;
                state_d = ST_ADJ;
              end
            end
            stq_pkg::REQ_DELETE: begin
              if (!id_act) begin
                status_d = stq_pkg::STS_NOT_ACTIVE;
              end else begin
                cmd.op               = stq_pkg::CELL_SHL;
                shl                  = pfx;
                active_d[timer_id_i] = 1'b0;
              end
            end
            stq_pkg::REQ_TICK: begin
              if (head_due) begin
                out_valid_d = out_valid_q && !out_ready_i;
                now_d       = now_time_i;
                state_d     = ST_TICK;
              end else begin
                kind_d = stq_pkg::KIND_NONE_DUE;
                oid_d  = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADJ: begin
        cmd     = '{op: stq_pkg::CELL_INS, id: id_q, expiry: exp_q};
        state_d = ST_IDLE;
      end
      ST_TICK: begin
        if (slot_free) begin
          // pop the head, which is known to be due
          cmd.op                = stq_pkg::CELL_SHL;
          shl                   = '1;
          active_d[ent[0].owner] = 1'b0;
          out_valid_d           = 1'b1;
          kind_d                = stq_pkg::KIND_EXPIRED;
          oid_d                 = ent[0].owner;
          oat_d                 = ent[0].expiry;
          status_d              = stq_pkg::STS_OK;
          last_d                = !next_due;
          if (!next_due) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    exp_q    <= exp_d;
    now_q    <= now_d;
    kind_q   <= kind_d;
    oid_q    <= oid_d;
    oat_q    <= oat_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign expired_id_o = oid_q;
  assign expired_at_o = oat_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

  // an adjusted timer stays active while it is out of the row
  a_active_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ADJ) |-> ($countones(active_q) == $countones(vld)))
    else $error("active flags disagree with occupied cells");

  a_packed_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld & (vld + DEPTH'(1))) == '0)
    else $error("occupied cells not contiguous from the head");

  a_tick_head_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK) |-> (ent[0].valid && (ent[0].expiry <= now_q)))
    else $error("expiry pass with no due head");

  a_adj_status_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADJ) |-> out_valid_q)
    else $error("adjust status not emitted");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned LIST_DEPTH = stq_pkg::DEPTH_DEFAULT;
  localparam int unsigned NUM_IDS    = stq_pkg::NUM_IDS;
  localparam int unsigned ID_W       = stq_pkg::ID_W;
  localparam int unsigned TIME_W     = stq_pkg::TIME_W;

  typedef struct packed {
    stq_pkg::kind_e    kind;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] at;
    stq_pkg::status_e  status;
    logic              last;
  } timer_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        req_type_i = stq_pkg::REQ_TICK;
  logic [ID_W-1:0]   timer_id_i = '0;
  logic [TIME_W-1:0] expire_time_i = '0;
  logic [TIME_W-1:0] now_time_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        kind_o;
  logic [ID_W-1:0]   expired_id_o;
  logic [TIME_W-1:0] expired_at_o;
  logic [1:0]        status_o;
  logic              last_o;

  // own copy of the sorted timer list
  logic [TIME_W-1:0] list_at [LIST_DEPTH];
  logic [ID_W-1:0]   list_owner [LIST_DEPTH];
  int unsigned       list_len = 0;
  bit                id_on [NUM_IDS];

  timer_result_t     awaited_results [$];
  int unsigned       gap_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       mismatches = 0;
  int unsigned       requests_sent = 0;
  int unsigned       results_seen = 0;
  int unsigned       expiries_seen = 0;
  logic [TIME_W-1:0] clock_now = '0;

  sorted_expiry_timer_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .timer_id_i   (timer_id_i),
    .expire_time_i(expire_time_i),
    .now_time_i   (now_time_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .expired_id_o (expired_id_o),
    .expired_at_o (expired_at_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic timer_result_t make_result(stq_pkg::kind_e k, logic [ID_W-1:0] id,
      logic [TIME_W-1:0] at, stq_pkg::status_e st, logic last);
    timer_result_t r;
    r.kind = k;
    r.id = id;
    r.at = at;
    r.status = st;
    r.last = last;
    return r;
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom());
  endfunction

  // place after every entry whose expiry is not later
  function automatic void list_insert(logic [ID_W-1:0] id, logic [TIME_W-1:0] exp);
    int unsigned pos;
    pos = 0;
    while (pos < list_len && list_at[pos] <= exp) pos++;
    for (int unsigned i = list_len; i > pos; i--) begin
      list_at[i] = list_at[i-1];
      list_owner[i] = list_owner[i-1];
    end
    list_at[pos] = exp;
    list_owner[pos] = id;
    list_len++;
  endfunction

  function automatic void list_remove_at(int unsigned pos);
    for (int unsigned i = pos; i + 1 < list_len; i++) begin
      list_at[i] = list_at[i+1];
      list_owner[i] = list_owner[i+1];
    end
    list_len--;
  endfunction

  function automatic void list_remove_id(logic [ID_W-1:0] id);
    for (int unsigned i = 0; i < list_len; i++) begin
      if (list_owner[i] == id) begin
        list_remove_at(i);
        return;
      end
    end
  endfunction

  function automatic void apply_to_timer_list(stq_pkg::req_e req, logic [ID_W-1:0] id,
      logic [TIME_W-1:0] exp, logic [TIME_W-1:0] now);
    stq_pkg::status_e st;
    int unsigned      popped;
    st = stq_pkg::STS_OK;
    popped = 0;
    if (req == stq_pkg::REQ_TICK) begin
      while (list_len > 0 && list_at[0] <= now) begin
        awaited_results.push_back(make_result(stq_pkg::KIND_EXPIRED, list_owner[0],
                                              list_at[0], stq_pkg::STS_OK, 1'b0));
        id_on[list_owner[0]] = 1'b0;
        list_remove_at(0);
        popped++;
      end
      if (popped == 0)
        awaited_results.push_back(make_result(stq_pkg::KIND_NONE_DUE, '0, '0,
                                              stq_pkg::STS_OK, 1'b1));
      else
        awaited_results[awaited_results.size()-1].last = 1'b1;
      return;
    end
    case (req)
      stq_pkg::REQ_ADD: begin
        if (id_on[id]) st = stq_pkg::STS_ACTIVE;
        else if (list_len >= LIST_DEPTH) st = stq_pkg::STS_FULL;
        else begin
          list_insert(id, exp);
          id_on[id] = 1'b1;
        end
      end
      stq_pkg::REQ_ADJUST: begin
        if (!id_on[id]) st = stq_pkg::STS_NOT_ACTIVE;
        else begin
          list_remove_id(id);
          list_insert(id, exp);
        end
      end
      default: begin
        if (!id_on[id]) st = stq_pkg::STS_NOT_ACTIVE;
        else begin
          list_remove_id(id);
          id_on[id] = 1'b0;
        end
      end
    endcase
    awaited_results.push_back(make_result(stq_pkg::KIND_STATUS, id, '0, st, 1'b1));
  endfunction

  // hold valid and payload until the request is taken
  task automatic issue_request(stq_pkg::req_e req, logic [ID_W-1:0] id,
      logic [TIME_W-1:0] exp, logic [TIME_W-1:0] now);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    timer_id_i <= id;
    expire_time_i <= exp;
    now_time_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    apply_to_timer_list(req, id, exp, now);
    requests_sent++;
  endtask

  function automatic void check_field(string name, logic [TIME_W-1:0] want,
      logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    timer_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d id %0d at %0h",
                 $time, kind_o, expired_id_o, expired_at_o);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", TIME_W'(want.kind), TIME_W'(kind_o));
        check_field("expired_id", TIME_W'(want.id), TIME_W'(expired_id_o));
        check_field("expired_at", want.at, expired_at_o);
        check_field("status", TIME_W'(want.status), TIME_W'(status_o));
        check_field("last", TIME_W'(want.last), TIME_W'(last_o));
        results_seen++;
        if (want.kind == stq_pkg::KIND_EXPIRED) expiries_seen++;
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [ID_W-1:0] pick_id(bit want_on);
    logic [ID_W-1:0] pool [$];
    for (int i = 0; i < NUM_IDS; i++)
      if (id_on[i] == want_on) pool.push_back(ID_W'(i));
    if (pool.size() == 0) return ID_W'($urandom_range(NUM_IDS-1));
    return pool[$urandom_range(pool.size()-1)];
  endfunction

  function automatic logic [TIME_W-1:0] pick_expiry();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 4) return '1;
    if (p < 7) return '0;
    if (p < 15) return $urandom();
    return clock_now + $urandom_range(60);
  endfunction

  task automatic test_empty_and_errors();
    issue_request(stq_pkg::REQ_TICK, rand_id(), $urandom(), '0);
    issue_request(stq_pkg::REQ_ADJUST, 6'd7, $urandom(), $urandom());
    issue_request(stq_pkg::REQ_DELETE, 6'd7, $urandom(), $urandom());
    issue_request(stq_pkg::REQ_ADD, 6'd7, 32'd20, $urandom());
    issue_request(stq_pkg::REQ_ADD, 6'd7, 32'd30, $urandom());
    issue_request(stq_pkg::REQ_TICK, rand_id(), $urandom(), 32'd19);
    issue_request(stq_pkg::REQ_DELETE, 6'd7, $urandom(), $urandom());
    issue_request(stq_pkg::REQ_DELETE, 6'd7, $urandom(), $urandom());
  endtask

  task automatic test_equal_expiry_order();
    issue_request(stq_pkg::REQ_ADD, 6'd5, 32'd100, $urandom());
    issue_request(stq_pkg::REQ_ADD, 6'd9, 32'd100, $urandom());
    issue_request(stq_pkg::REQ_ADD, 6'd12, 32'd40, $urandom());
    // equal expiry moves the timer behind its peers
    issue_request(stq_pkg::REQ_ADJUST, 6'd5, 32'd100, $urandom());
    issue_request(stq_pkg::REQ_ADJUST, 6'd12, 32'd100, $urandom());
    issue_request(stq_pkg::REQ_ADJUST, 6'd9, 32'd50, $urandom());
    issue_request(stq_pkg::REQ_TICK, rand_id(), $urandom(), 32'd100);
  endtask

  task automatic test_extreme_times();
    issue_request(stq_pkg::REQ_ADD, 6'd0, '1, '0);
    issue_request(stq_pkg::REQ_ADD, 6'd63, '0, '1);
    issue_request(stq_pkg::REQ_ADD, 6'd1, '1, $urandom());
    issue_request(stq_pkg::REQ_ADJUST, 6'd0, '1, $urandom());
    issue_request(stq_pkg::REQ_TICK, 6'd63, '1, '0);
    issue_request(stq_pkg::REQ_TICK, 6'd0, '0, 32'hFFFF_FFFE);
    issue_request(stq_pkg::REQ_TICK, rand_id(), $urandom(), '1);
  endtask

  task automatic test_random_traffic(int unsigned gap, int unsigned stall,
      int unsigned count);
    int unsigned p;
    gap_pct = gap;
    stall_pct = stall;
    for (int unsigned n = 0; n < count; n++) begin
      p = $urandom_range(99);
      if (p < 8)
        issue_request(stq_pkg::req_e'($urandom_range(3)), rand_id(), $urandom(),
                      $urandom());
      else if (p < 45)
        issue_request(stq_pkg::REQ_ADD, pick_id($urandom_range(9) == 0), pick_expiry(),
                      $urandom());
      else if (p < 60)
        issue_request(stq_pkg::REQ_ADJUST, pick_id($urandom_range(9) != 0),
                      pick_expiry(), $urandom());
      else if (p < 73)
        issue_request(stq_pkg::REQ_DELETE, pick_id($urandom_range(9) != 0), $urandom(),
                      $urandom());
      else begin
        clock_now = clock_now + $urandom_range(40);
        p = $urandom_range(99);
        issue_request(stq_pkg::REQ_TICK, rand_id(), $urandom(),
                      p < 5 ? '1 : (p < 10 ? $urandom() : clock_now));
      end
    end
  endtask

  task automatic test_fill_and_flush();
    logic [TIME_W-1:0] base;
    gap_pct = 12;
    stall_pct = 49;
    base = $urandom_range(1000, 100000);
    while (list_len < LIST_DEPTH)
      issue_request(stq_pkg::REQ_ADD, pick_id(1'b0), base + $urandom_range(7), $urandom());
    issue_request(stq_pkg::REQ_ADD, pick_id(1'b1), $urandom(), $urandom());
    issue_request(stq_pkg::REQ_ADJUST, pick_id(1'b1), base - 1, $urandom());
    issue_request(stq_pkg::REQ_ADJUST, pick_id(1'b1), '1, $urandom());
    // every timer expires in one tick
    issue_request(stq_pkg::REQ_TICK, rand_id(), $urandom(), '1);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    clock_now = $urandom_range(1000);
    test_empty_and_errors();
    test_equal_expiry_order();
    test_extreme_times();
    test_random_traffic(0, 0, 55);
    test_random_traffic(49, 0, 55);
    test_random_traffic(0, 49, 55);
    test_random_traffic(12, 12, 55);
    test_fill_and_flush();
    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d timer requests under four idle/stall mixes plus a full-list flush;",
             requests_sent);
    $display("checked %0d results, %0d of them expirations, with %0d mismatches.",
             results_seen, expiries_seen, mismatches);
    if (mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still outstanding.", awaited_results.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
